FILE: rtl/wbf_pkg.sv
// ----------------------------------------------------------------------------
// wbf_pkg: shared types and constants for the forward word boundary search
// Byte classes, search phases and the byte classifier.
// ----------------------------------------------------------------------------
package wbf_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_NEWLINE = 3'd1,
        PH_CR      = 3'd2,
        PH_BLANK   = 3'd3,
        PH_RUN     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CL_BLANK = 2'd0,
        CL_BREAK = 2'd1,
        CL_SEP   = 2'd2,
        CL_WORD  = 2'd3
    } byte_class_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // ASCII punctuation ranges; underscore is a word byte
    localparam logic [7:0] CH_PUNCT_A_LO = 8'h21;  // '!'
    localparam logic [7:0] CH_PUNCT_A_HI = 8'h2F;  // '/'
    localparam logic [7:0] CH_PUNCT_B_LO = 8'h3A;  // ':'
    localparam logic [7:0] CH_PUNCT_B_HI = 8'h40;  // '@'
    localparam logic [7:0] CH_PUNCT_C_LO = 8'h5B;  // '['
    localparam logic [7:0] CH_PUNCT_C_HI = 8'h5E;  // '^'
    localparam logic [7:0] CH_BACKTICK   = 8'h60;  // '`'
    localparam logic [7:0] CH_PUNCT_D_LO = 8'h7B;  // '{'
    localparam logic [7:0] CH_PUNCT_D_HI = 8'h7E;  // '~'

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cls;
        begin
            case (b) inside
                CH_SPACE, CH_TAB:
                    cls = CL_BLANK;
                CH_LF, CH_CR:
                    cls = CL_BREAK;
                [CH_PUNCT_A_LO:CH_PUNCT_A_HI],
                [CH_PUNCT_B_LO:CH_PUNCT_B_HI],
                [CH_PUNCT_C_LO:CH_PUNCT_C_HI],
                CH_BACKTICK,
                [CH_PUNCT_D_LO:CH_PUNCT_D_HI]:
                    cls = CL_SEP;
                default:
                    cls = CL_WORD;
            endcase
            return cls;
        end
    endfunction

endpackage

FILE: rtl/word_boundary_forward_top.sv
// ----------------------------------------------------------------------------
// word_boundary_forward_top: forward word boundary search over a byte stream
// Classifies one document byte per item and reports the boundary offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one document byte per item. An item
//   with first=1 starts a search at start_offset; at_end=1 marks end of
//   document and carries no byte. Items with first=0 while no search runs
//   are dropped silently. first=1 mid-search restarts the search.
//   Output channel (out_valid / out_stall): one end_offset item per search
//   that is not restarted, given by the item that ends it (byte outside the run,
//   a byte other than LF after a leading CR, a newline after the leading skip, or end of document).
// Timing:
//   An accepted item sits in the input register; the byte class and phase
//   update happen between it and the result register, which loads when the
//   item moves on. One item per cycle sustained while the output is not
//   stalled; the only loop is the phase/position update through the search
//   state registers.
// Stall: a full result register holds while out_stall is high; the input
//   register then holds its item and in_stall rises. No item is lost.
// Reset: rst_n clears phase to idle, position and run flags to zero, and
//   empties both registers.
// ----------------------------------------------------------------------------
module word_boundary_forward_top
    import wbf_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        first,
    input  logic [31:0] start_offset,
    input  logic [7:0]  text_byte,
    input  logic        at_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] end_offset
);

    // input register
    logic        s1_valid_reg;
    logic        s1_first_reg;
    logic [31:0] s1_start_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;

    // search state
    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic                   run_sep_reg, run_sep_next;
    logic                   run_ext_reg, run_ext_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] end_offset_reg;

    logic        can_move;
    logic        s1_fire;
    logic        done;
    byte_class_t cls;

    phase_t                 ph_eff;
    logic [OFFSET_BITS-1:0] pos_eff;
    logic                   sep_eff;
    logic                   ext_eff;
    logic [OFFSET_BITS:0]   sum1;
    logic [OFFSET_BITS:0]   sum2;
    logic [OFFSET_BITS-1:0] pos_inc1;
    logic [OFFSET_BITS-1:0] pos_inc2;

    // handshake
    assign can_move  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && can_move;
    assign in_stall  = s1_valid_reg && !can_move;
    assign out_valid = out_valid_reg;
    assign end_offset = end_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_first_reg <= first;
            s1_start_reg <= start_offset;
            s1_byte_reg  <= text_byte;
            s1_end_reg   <= at_end;
        end
    end

    // a new search overrides the current state for this item
    assign ph_eff  = s1_first_reg ? PH_NEWLINE : phase_reg;
    assign pos_eff = s1_first_reg ? OFFSET_BITS'(s1_start_reg) : position_reg;
    assign sep_eff = s1_first_reg ? 1'b0 : run_sep_reg;
    assign ext_eff = s1_first_reg ? 1'b0 : run_ext_reg;

    // saturating advance by one and by two (CR LF)
    assign sum1     = {1'b0, pos_eff} + (OFFSET_BITS+1)'(1);
    assign sum2     = {1'b0, pos_eff} + (OFFSET_BITS+1)'(2);
    assign pos_inc1 = sum1[OFFSET_BITS] ? '1 : sum1[OFFSET_BITS-1:0];
    assign pos_inc2 = sum2[OFFSET_BITS] ? '1 : sum2[OFFSET_BITS-1:0];

    assign cls = classify(s1_byte_reg);

    always_comb
    begin
        phase_next    = ph_eff;
        position_next = pos_eff;
        run_sep_next  = sep_eff;
        run_ext_next  = ext_eff;
        done          = 1'b0;

        if (ph_eff != PH_IDLE && s1_end_reg)
        begin
            done = 1'b1;
        end
        else
        begin
            unique case (ph_eff)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_NEWLINE, PH_BLANK:
                begin
                    if (ph_eff == PH_NEWLINE && s1_byte_reg == CH_LF)
                    begin
                        position_next = pos_inc1;
                        phase_next    = PH_BLANK;
                    end
                    else if (ph_eff == PH_NEWLINE && s1_byte_reg == CH_CR)
                    begin
                        phase_next = PH_CR;
                    end
                    else if (cls == CL_BLANK)
                    begin
                        position_next = pos_inc1;
                        phase_next    = PH_BLANK;
                    end
                    else if (cls == CL_BREAK)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        position_next = pos_inc1;
                        run_sep_next  = (cls == CL_SEP);
                        run_ext_next  = 1'b0;
                        phase_next    = PH_RUN;
                    end
                end
                PH_CR:
                begin
                    if (s1_byte_reg == CH_LF)
                    begin
                        position_next = pos_inc2;
                        phase_next    = PH_BLANK;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                PH_RUN:
                begin
                    if (cls == (sep_eff ? CL_SEP : CL_WORD))
                    begin
                        position_next = pos_inc1;
                        run_ext_next  = 1'b1;
                    end
                    else if (sep_eff && !ext_eff && cls == CL_WORD)
                    begin
                        // lone punctuation byte absorbs the word after it
                        position_next = pos_inc1;
                        run_sep_next  = 1'b0;
                        run_ext_next  = 1'b1;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (done)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            position_reg <= '0;
            run_sep_reg  <= 1'b0;
            run_ext_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            run_sep_reg  <= run_sep_next;
            run_ext_reg  <= run_ext_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= done;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && done)
        begin
            end_offset_reg <= 32'(pos_eff);
        end
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while result register can move");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the input register");

    a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (phase_reg == PH_IDLE))
        else $error("search still running after its result");

    a_position_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_first_reg && phase_reg != PH_IDLE)
            |=> (position_reg >= $past(position_reg)))
        else $error("position moved backward within a search");

endmodule

FILE: tb/tb_word_boundary_forward_top.sv
// ----------------------------------------------------------------------------
// tb_word_boundary_forward_top: self-checking bench for the forward word search
// Runs a short table of hand-picked searches, then random searches built from
// newline prefixes, blank skips and word or punctuation runs. Boundaries come
// from a cycle-free predictor, or are typed in by hand for fixed table rows.
// ----------------------------------------------------------------------------
module tb_word_boundary_forward_top;
    import wbf_pkg::*;

    localparam int          OFFSET_BITS  = 32;
    localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;  // saturation point
    localparam int          RANDOM_ITEMS = 900;
    localparam int          HOLD_CYCLES  = 64;    // long receiver hold-off
    localparam int          IDLE_LIMIT   = 2000;  // cycles with no handshake
    localparam int          TAIL_CYCLES  = 8;     // wait after drain for any surplus result

    // one input item, as it sits on the ports
    typedef struct packed {
        logic        first;
        logic [31:0] start_offset;
        logic [7:0]  text_byte;
        logic        at_end;
    } text_item_t;

    // directed table row: fixed=1 means the boundary is typed in by hand
    typedef struct packed {
        text_item_t  item;
        logic        fixed;
        logic [31:0] bound;
    } text_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        first        = 1'b0;
    logic [31:0] start_offset = '0;
    logic [7:0]  text_byte    = '0;
    logic        at_end       = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [31:0] end_offset;

    word_boundary_forward_top #(
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first        (first),
        .start_offset (start_offset),
        .text_byte    (text_byte),
        .at_end       (at_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .end_offset   (end_offset)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the search, advanced once per intake
    // ------------------------------------------------------------------------
    phase_t      srch_phase = PH_IDLE;
    logic [31:0] srch_pos   = '0;
    bit          run_sep    = 1'b0;   // run is punctuation, else word
    bit          run_long   = 1'b0;   // run holds more than its first byte

    logic [31:0] pending_bounds[$];   // boundaries still owed by the block

    int  items_live   = 0;   // items that reached a running search
    int  searches     = 0;
    int  restarts     = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  holds_done   = 0;
    int  idle_cycles  = 0;

    bit  hold_req = 1'b0;    // sender asks the receiver for a long hold-off
    bit  squeeze  = 1'b0;    // sender runs back to back while the hold lasts

    string SEP_CHARS = "`~!@#$%^&*()-=+[{]}\\|;:'\",.<>/?";

    // Punctuation is any printable ASCII byte that is not alphanumeric or
    // underscore; everything outside 0x21..0x7E that is not blank or newline
    // counts as a word byte.
    function automatic byte_class_t class_of(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_TAB)
            return CL_BLANK;
        if (b == CH_LF || b == CH_CR)
            return CL_BREAK;
        if (b < 8'h21 || b > 8'h7E)
            return CL_WORD;
        if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F)
            return CL_WORD;
        return CL_SEP;
    endfunction

    function automatic void bump_pos();
        if (srch_pos != POS_MAX)
            srch_pos = srch_pos + 32'd1;
    endfunction

    // blank-skip phase; returns 1 when the search stops on this byte
    function automatic bit skip_blank(input byte_class_t cls);
        if (cls == CL_BLANK)
        begin
            bump_pos();
            return 1'b0;
        end
        if (cls == CL_BREAK)
            return 1'b1;
        bump_pos();
        run_sep    = (cls == CL_SEP);
        run_long   = 1'b0;
        srch_phase = PH_RUN;
        return 1'b0;
    endfunction

    // Advances the search by one item; returns 1 and the boundary when the
    // item ends the search.
    function automatic bit boundary_step(input text_item_t it, output logic [31:0] bound);
        byte_class_t cls;
        byte_class_t own;
        bit          done;
        cls   = class_of(it.text_byte);
        done  = 1'b0;
        bound = '0;
        if (it.first)
        begin
            srch_pos   = it.start_offset;
            run_sep    = 1'b0;
            run_long   = 1'b0;
            srch_phase = PH_NEWLINE;
        end
        if (srch_phase == PH_IDLE)
            return 1'b0;
        if (it.at_end)
            done = 1'b1;
        else
        begin
            case (srch_phase)
                PH_NEWLINE:
                begin
                    if (it.text_byte == CH_LF)
                    begin
                        bump_pos();
                        srch_phase = PH_BLANK;
                    end
                    else if (it.text_byte == CH_CR)
                        srch_phase = PH_CR;
                    else
                    begin
                        srch_phase = PH_BLANK;
                        done = skip_blank(cls);
                    end
                end
                PH_CR:
                begin
                    // CR LF is skipped as a pair; a lone CR stops the search
                    if (it.text_byte == CH_LF)
                    begin
                        bump_pos();
                        bump_pos();
                        srch_phase = PH_BLANK;
                    end
                    else
                        done = 1'b1;
                end
                PH_BLANK:
                    done = skip_blank(cls);
                default:
                begin
                    own = run_sep ? CL_SEP : CL_WORD;
                    if (cls == own)
                    begin
                        bump_pos();
                        run_long = 1'b1;
                    end
                    else if (run_sep && !run_long && cls == CL_WORD)
                    begin
                        // single punctuation byte swallows the word after it
                        bump_pos();
                        run_sep  = 1'b0;
                        run_long = 1'b1;
                    end
                    else
                        done = 1'b1;
                end
            endcase
        end
        bound = srch_pos;
        if (done)
            srch_phase = PH_IDLE;
        return done;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] byte_of(input byte_class_t cls);
        case (cls)
            CL_BLANK: return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            CL_BREAK: return $urandom_range(0, 1) ? CH_LF : CH_CR;
            CL_SEP:   return SEP_CHARS[$urandom_range(0, SEP_CHARS.len() - 1)];
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return 8'($urandom_range(8'h61, 8'h7A));  // lower case
                    1: return 8'($urandom_range(8'h41, 8'h5A));  // upper case
                    2: return 8'($urandom_range(8'h30, 8'h39));  // digits
                    3: return 8'($urandom_range(8'h80, 8'hFF));  // non-ASCII
                    4: return 8'($urandom_range(8'h00, 8'h08));  // control
                    default: return $urandom_range(0, 1) ? 8'h5F : 8'h7F;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom;
        if (r < 85)
            return 32'($urandom_range(0, 15));
        return POS_MAX - 32'($urandom_range(0, 15));  // saturation corner
    endfunction

    // mostly back to back or short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic text_row_t row(input logic f, input logic [31:0] off,
                                      input logic [7:0] b, input logic e,
                                      input logic fixed, input logic [31:0] bound);
        text_row_t r;
        r.item  = '{first: f, start_offset: off, text_byte: b, at_end: e};
        r.fixed = fixed;
        r.bound = bound;
        return r;
    endfunction

    // Drive one item at the falling edge, hold it until taken, then predict.
    task automatic offer(input text_item_t it, input logic fixed,
                         input logic [31:0] fixed_bound);
        int          gap;
        bit          hit;
        logic [31:0] bound;
        // every fourth block of 100 items runs with no input gaps at all
        gap = (squeeze || (items_live / 100) % 4 == 1) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        first        <= it.first;
        start_offset <= it.start_offset;
        text_byte    <= it.text_byte;
        at_end       <= it.at_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (it.first && srch_phase != PH_IDLE)
            restarts++;
        if (it.first)
            searches++;
        if (it.first || srch_phase != PH_IDLE)
            items_live++;
        hit = boundary_step(it, bound);
        if (fixed)
            pending_bounds.push_back(fixed_bound);
        else if (hit)
            pending_bounds.push_back(bound);
    endtask

    // ------------------------------------------------------------------------
    // Directed table: hand-typed boundaries where they are obvious
    // ------------------------------------------------------------------------
    text_row_t dir_rows [27];

    initial
    begin
        dir_rows = '{
            // stray item while no search runs: dropped
            row(1'b0, 32'd0,         8'h61,    1'b0, 1'b0, 32'd0),
            // end of document on the very first item
            row(1'b1, 32'd0,         8'h00,    1'b1, 1'b1, 32'd0),
            // word at the top offset: position pins at the maximum
            row(1'b1, POS_MAX,       8'h61,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         CH_SPACE, 1'b0, 1'b1, POS_MAX),
            // lone CR is not skipped
            row(1'b1, 32'd100,       CH_CR,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h78,    1'b0, 1'b1, 32'd100),
            // CR LF, blanks, then a short word ended by punctuation
            row(1'b1, 32'd200,       CH_CR,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         CH_LF,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         CH_SPACE, 1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         CH_TAB,   1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h77,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h2E,    1'b0, 1'b1, 32'd205),
            // one LF skipped, the second one stops the search
            row(1'b1, 32'd300,       CH_LF,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         CH_LF,    1'b0, 1'b1, 32'd301),
            // single '(' swallows the word after it
            row(1'b1, 32'd400,       8'h28,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h61,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h7E,    1'b0, 1'b1, 32'd402),
            // punctuation run of two does not swallow a word
            row(1'b1, 32'd500,       8'h2D,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h2D,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'h61,    1'b0, 1'b1, 32'd502),
            // restart mid-search; underscore is word, backtick is punctuation
            row(1'b1, 32'd600,       8'h5F,    1'b0, 1'b0, 32'd0),
            row(1'b1, 32'd700,       8'h60,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         CH_SPACE, 1'b0, 1'b1, 32'd701),
            // end of document while checking for CR LF
            row(1'b1, 32'd800,       CH_CR,    1'b0, 1'b0, 32'd0),
            row(1'b0, 32'd0,         8'hFF,    1'b1, 1'b1, 32'd800),
            // byte extremes as word bytes, offset crossing bit 31
            row(1'b1, 32'h7FFF_FFFF, 8'h00,    1'b0, 1'b0, 32'd0),
            row(1'b0, POS_MAX,       8'hFF,    1'b1, 1'b1, 32'h8000_0000)
        };
    end

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, then random searches
    // ------------------------------------------------------------------------
    initial
    begin
        text_item_t  it;
        logic [7:0]  text_q[$];
        bit          end_mark;
        int          cut;
        int          next_hold;
        int          live_start;
        next_hold = 300;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].bound);

        live_start = items_live;
        while (items_live - live_start < RANDOM_ITEMS)
        begin
            // twice in the run the receiver holds off while we keep pushing
            if (items_live - live_start >= next_hold)
            begin
                hold_req  = 1'b1;
                squeeze   = 1'b1;
                next_hold = next_hold + 350;
            end

            text_q.delete();
            if ($urandom_range(0, 9) < 7)
            begin
                // well-formed: newline prefix, blanks, a run, a closing byte
                case ($urandom_range(0, 4))
                    0: text_q.push_back(CH_LF);
                    1:
                    begin
                        text_q.push_back(CH_CR);
                        text_q.push_back(CH_LF);
                    end
                    2: text_q.push_back(CH_CR);
                    default: ;
                endcase
                repeat ($urandom_range(0, 3))
                    text_q.push_back(byte_of(CL_BLANK));
                case ($urandom_range(0, 2))
                    0: repeat ($urandom_range(1, 5)) text_q.push_back(byte_of(CL_WORD));
                    1: repeat ($urandom_range(1, 4)) text_q.push_back(byte_of(CL_SEP));
                    default:
                    begin
                        text_q.push_back(byte_of(CL_SEP));
                        repeat ($urandom_range(1, 5))
                            text_q.push_back(byte_of(CL_WORD));
                    end
                endcase
                text_q.push_back(byte_of(byte_class_t'($urandom_range(0, 3))));
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end

            // sometimes the document ends part way through
            end_mark = ($urandom_range(0, 4) == 0);
            if (end_mark)
            begin
                cut = $urandom_range(0, text_q.size());
                while (text_q.size() > cut)
                    void'(text_q.pop_back());
                text_q.push_back(8'($urandom_range(0, 255)));
            end

            foreach (text_q[i])
            begin
                it.first        = (i == 0);
                it.start_offset = (i == 0) ? pick_offset() : $urandom;
                it.text_byte    = text_q[i];
                it.at_end       = end_mark && (i == text_q.size() - 1);
                offer(it, 1'b0, 32'd0);
            end

            // noise: stray items between searches
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    it.first        = 1'b0;
                    it.start_offset = $urandom;
                    it.text_byte    = 8'($urandom_range(0, 255));
                    it.at_end       = 1'($urandom_range(0, 1));
                    offer(it, 1'b0, 32'd0);
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then give the block time to show any surplus result
        while (pending_bounds.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d live items over %0d searches (%0d restarts)",
                 items_live, searches, restarts);
        $display("%0d boundaries checked, %0d long receiver holds",
                 results_seen, holds_done);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, and long holds on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // long hold-off: the block fills and pushes back on its input
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req  = 1'b0;
                squeeze   = 1'b0;
                holds_done++;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if ((results_seen / 25) % 4 == 1)
                out_stall <= 1'b0;   // quiet stretch
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall  <= 1'b1;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(4, 29);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest pending boundary
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_bounds.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got end_offset %h",
                         $time, end_offset);
            end
            else
            begin
                want = pending_bounds.pop_front();
                if (end_offset !== want)
                begin
                    mismatches++;
                    $display("%0t: end_offset mismatch, expected %h, got %h",
                             $time, want, end_offset);
                end
            end
        end
    end

    // watchdog: no handshake on either side for too long ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no handshake for %0d cycles, %0d results owed",
                     $time, IDLE_LIMIT, pending_bounds.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
